@@ rtl/lkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants for the LRU key-value cache
// Entry count, derived widths, payload structs, sequencer states and the
// command bundle between the sequencer and the key/value store.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   // table size and derived widths
   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int CSR_W  = 5;
   localparam int CAP_W  = (CNT_W > CSR_W) ? CNT_W : CSR_W;
   localparam int DATA_W = 32;

   localparam logic [CSR_W-1:0] CAP_RESET = CSR_W'(16);

   // request kinds
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   typedef struct packed {
      logic                     req_type;
      logic signed [DATA_W-1:0] lookup_key;
      logic signed [DATA_W-1:0] write_value;
   } lkvc_request_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] read_value;
   } lkvc_response_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_RESP
   } lkvc_state_type;

   // sequencer to store: one read port per memory, one shared write address
   typedef struct packed {
      logic                     key_rd_en;
      logic [IDX_W-1:0]         key_rd_addr;
      logic                     val_rd_en;
      logic [IDX_W-1:0]         val_rd_addr;
      logic                     wr_en;
      logic [IDX_W-1:0]         wr_addr;
      logic signed [DATA_W-1:0] wr_key;
      logic signed [DATA_W-1:0] wr_value;
   } lkvc_store_cmd_type;

endpackage

@@ rtl/lkvc_store.sv @@
// ----------------------------------------------------------------------------
// lkvc_store: key and value memories
// One write address shared by both memories, one registered read port each.
// ----------------------------------------------------------------------------
module lkvc_store (
   input  logic                                clock,
   input  lkvc_pkg::lkvc_store_cmd_type        cmd,
   output logic signed [lkvc_pkg::DATA_W-1:0]  rd_key,
   output logic signed [lkvc_pkg::DATA_W-1:0]  rd_value
);

   logic signed [lkvc_pkg::DATA_W-1:0] key_mem [lkvc_pkg::MAX_ENTRIES];
   logic signed [lkvc_pkg::DATA_W-1:0] val_mem [lkvc_pkg::MAX_ENTRIES];
   logic signed [lkvc_pkg::DATA_W-1:0] rd_key_ff;
   logic signed [lkvc_pkg::DATA_W-1:0] rd_value_ff;

   // write both memories at the chosen entry
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         key_mem[cmd.wr_addr] <= cmd.wr_key;
         val_mem[cmd.wr_addr] <= cmd.wr_value;
      end
   end

   // registered reads; hold the last word when not enabled
   always_ff @(posedge clock) begin
      if (cmd.key_rd_en) begin
         rd_key_ff <= key_mem[cmd.key_rd_addr];
      end
      if (cmd.val_rd_en) begin
         rd_value_ff <= val_mem[cmd.val_rd_addr];
      end
   end

   assign rd_key   = rd_key_ff;
   assign rd_value = rd_value_ff;

endmodule

@@ rtl/lkvc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lkvc_ctrl: request sequencer with the shared key comparator
// Scans the entries one a cycle through a single comparator, then, except on a
// get miss or a put at capacity zero, walks the recency ranks one a cycle to
// promote or insert. Holds valid bits, ranks and the fill count.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [lkvc_pkg::CSR_W-1:0]          capacity,
   input  logic                                req_valid,
   input  lkvc_pkg::lkvc_request_type          req_data,
   output logic                                idle,
   input  logic                                out_free,
   output logic                                rsp_load,
   output lkvc_pkg::lkvc_response_type         rsp_next,
   output lkvc_pkg::lkvc_store_cmd_type        store_cmd,
   input  logic signed [lkvc_pkg::DATA_W-1:0]  rd_key,
   input  logic signed [lkvc_pkg::DATA_W-1:0]  rd_value
);

   localparam logic [lkvc_pkg::CNT_W-1:0] CNT_MAX  = lkvc_pkg::CNT_W'(lkvc_pkg::MAX_ENTRIES);
   localparam logic [lkvc_pkg::CNT_W-1:0] CNT_LAST =
      lkvc_pkg::CNT_W'(lkvc_pkg::MAX_ENTRIES - 1);
   localparam logic [lkvc_pkg::CAP_W-1:0] CAP_MAX  = lkvc_pkg::CAP_W'(lkvc_pkg::MAX_ENTRIES);

   lkvc_pkg::lkvc_state_type          state_ff, state_in;
   lkvc_pkg::lkvc_request_type        req_ff, req_in;
   logic [lkvc_pkg::CNT_W-1:0]        idx_ff, idx_in;

   // compare stage, used in the cycle after the key read is issued
   logic                              cmp_pend_ff, cmp_pend_in;
   logic                              cmp_valid_ff, cmp_valid_in;
   logic [lkvc_pkg::IDX_W-1:0]        cmp_idx_ff, cmp_idx_in;
   logic [lkvc_pkg::RANK_W-1:0]       cmp_rank_ff, cmp_rank_in;

   // scan results
   logic                              hit_ff, hit_in;
   logic [lkvc_pkg::IDX_W-1:0]        hit_idx_ff, hit_idx_in;
   logic [lkvc_pkg::RANK_W-1:0]       hit_rank_ff, hit_rank_in;
   logic                              free_ff, free_in;
   logic [lkvc_pkg::IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic                              lru_ff, lru_in;
   logic [lkvc_pkg::IDX_W-1:0]        lru_idx_ff, lru_idx_in;
   logic [lkvc_pkg::RANK_W-1:0]       lru_rank_ff, lru_rank_in;

   // rank update pass
   logic [lkvc_pkg::IDX_W-1:0]        target_ff, target_in;
   logic [lkvc_pkg::CNT_W-1:0]        thresh_ff, thresh_in;

   // table state
   logic                              valid_ff [lkvc_pkg::MAX_ENTRIES];
   logic [lkvc_pkg::RANK_W-1:0]       rank_ff  [lkvc_pkg::MAX_ENTRIES];
   logic [lkvc_pkg::CNT_W-1:0]        fill_ff, fill_in;

   logic                              valid_set;
   logic [lkvc_pkg::IDX_W-1:0]        valid_idx;
   logic                              rank_we;
   logic [lkvc_pkg::RANK_W-1:0]       rank_wdata;

   logic [lkvc_pkg::IDX_W-1:0]        cur;
   logic                              cur_valid;
   logic [lkvc_pkg::RANK_W-1:0]       cur_rank;
   logic [lkvc_pkg::CAP_W-1:0]        cap_ext;
   logic [lkvc_pkg::CAP_W-1:0]        cap_eff;
   logic [lkvc_pkg::CAP_W-1:0]        fill_ext;

   assign cur       = idx_ff[lkvc_pkg::IDX_W-1:0];
   assign cur_valid = valid_ff[cur];
   assign cur_rank  = rank_ff[cur];

   // saturate the capacity register to the table size
   assign cap_ext  = lkvc_pkg::CAP_W'(capacity);
   assign cap_eff  = (cap_ext > CAP_MAX) ? CAP_MAX : cap_ext;
   assign fill_ext = lkvc_pkg::CAP_W'(fill_ff);

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lkvc_pkg::ST_IDLE;
         cmp_pend_ff <= 1'b0;
         fill_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         cmp_pend_ff <= cmp_pend_in;
         fill_ff     <= fill_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      idx_ff       <= idx_in;
      cmp_valid_ff <= cmp_valid_in;
      cmp_idx_ff   <= cmp_idx_in;
      cmp_rank_ff  <= cmp_rank_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_rank_ff  <= hit_rank_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      lru_ff       <= lru_in;
      lru_idx_ff   <= lru_idx_in;
      lru_rank_ff  <= lru_rank_in;
      target_ff    <= target_in;
      thresh_ff    <= thresh_in;
   end

   // valid bits and recency ranks
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            rank_ff[i]  <= '0;
         end
      end else begin
         if (valid_set) begin
            valid_ff[valid_idx] <= 1'b1;
         end
         if (rank_we) begin
            rank_ff[cur] <= rank_wdata;
         end
      end
   end

   // sequencer: next state, datapath control and store commands
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      cmp_pend_in  = 1'b0;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_rank_in  = cmp_rank_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_rank_in  = hit_rank_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      lru_in       = lru_ff;
      lru_idx_in   = lru_idx_ff;
      lru_rank_in  = lru_rank_ff;
      target_in    = target_ff;
      thresh_in    = thresh_ff;
      fill_in      = fill_ff;
      valid_set    = 1'b0;
      valid_idx    = free_idx_ff;
      rank_we      = 1'b0;
      rank_wdata   = '0;
      idle         = 1'b0;
      rsp_load     = 1'b0;
      rsp_next.hit        = hit_ff;
      rsp_next.read_value = hit_ff ? rd_value : '1;
      store_cmd.key_rd_en   = 1'b0;
      store_cmd.key_rd_addr = cur;
      store_cmd.val_rd_en   = 1'b0;
      store_cmd.val_rd_addr = hit_idx_ff;
      store_cmd.wr_en       = 1'b0;
      store_cmd.wr_addr     = hit_idx_ff;
      store_cmd.wr_key      = req_ff.lookup_key;
      store_cmd.wr_value    = req_ff.write_value;

      unique case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            idle = 1'b1;
            // take a request and clear the scan results
            if (req_valid) begin
               req_in   = req_data;
               idx_in   = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               lru_in   = 1'b0;
               state_in = lkvc_pkg::ST_SCAN;
            end
         end

         lkvc_pkg::ST_SCAN: begin
            // issue the key read and track free and least recent entries
            if (idx_ff != CNT_MAX) begin
               store_cmd.key_rd_en = 1'b1;
               cmp_pend_in  = 1'b1;
               cmp_valid_in = cur_valid;
               cmp_idx_in   = cur;
               cmp_rank_in  = cur_rank;
               if (!cur_valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = cur;
               end
               if (cur_valid && (!lru_ff || cur_rank > lru_rank_ff)) begin
                  lru_in      = 1'b1;
                  lru_idx_in  = cur;
                  lru_rank_in = cur_rank;
               end
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = lkvc_pkg::ST_DECIDE;
            end
            // shared comparator on the key read last cycle
            if (cmp_pend_ff && cmp_valid_ff && !hit_ff && rd_key == req_ff.lookup_key) begin
               hit_in      = 1'b1;
               hit_idx_in  = cmp_idx_ff;
               hit_rank_in = cmp_rank_ff;
            end
         end

         lkvc_pkg::ST_DECIDE: begin
            idx_in    = '0;
            target_in = hit_idx_ff;
            thresh_in = lkvc_pkg::CNT_W'(hit_rank_ff);
            if (req_ff.req_type == lkvc_pkg::REQ_GET) begin
               // fetch the value on a hit, then promote
               if (hit_ff) begin
                  store_cmd.val_rd_en = 1'b1;
                  state_in = lkvc_pkg::ST_UPDATE;
               end else begin
                  state_in = lkvc_pkg::ST_RESP;
               end
            end else if (cap_eff == '0) begin
               state_in = lkvc_pkg::ST_IDLE;
            end else if (hit_ff) begin
               // update in place
               store_cmd.wr_en = 1'b1;
               state_in = lkvc_pkg::ST_UPDATE;
            end else if (fill_ext < cap_eff) begin
               // fill a free entry; every valid entry ages by one
               store_cmd.wr_en   = 1'b1;
               store_cmd.wr_addr = free_idx_ff;
               valid_set = 1'b1;
               fill_in   = fill_ff + 1'b1;
               target_in = free_idx_ff;
               thresh_in = CNT_MAX;
               state_in  = lkvc_pkg::ST_UPDATE;
            end else begin
               // replace the least recent entry
               store_cmd.wr_en   = 1'b1;
               store_cmd.wr_addr = lru_idx_ff;
               target_in = lru_idx_ff;
               thresh_in = lkvc_pkg::CNT_W'(lru_rank_ff);
               state_in  = lkvc_pkg::ST_UPDATE;
            end
         end

         lkvc_pkg::ST_UPDATE: begin
            // target becomes most recent; younger valid entries age by one
            if (cur == target_ff) begin
               rank_we    = 1'b1;
               rank_wdata = '0;
            end else if (cur_valid && lkvc_pkg::CNT_W'(cur_rank) < thresh_ff) begin
               rank_we    = 1'b1;
               rank_wdata = cur_rank + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == CNT_LAST) begin
               state_in = (req_ff.req_type == lkvc_pkg::REQ_GET) ? lkvc_pkg::ST_RESP
                                                                 : lkvc_pkg::ST_IDLE;
            end
         end

         lkvc_pkg::ST_RESP: begin
            // hand the result to the output register once it is free
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = lkvc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lkvc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache, LRU replacement
// Get and put requests; a get returns hit and value (-1 on a miss), a put
// returns nothing. Recency is kept as one rank per entry.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid / req_stall lkvc_request_type
//   rsp_      out        rsp_valid / rsp_stall lkvc_response_type
//   csr_      in         csr_wr_en             active capacity, 5 bits
//
// From one request to the next, a get hit and a put that stores go through the
// single key comparator scan plus the rank walk; a get miss skips the walk, as
// does a put at capacity zero. req_stall is high while a request is in flight.
// A result waits in the output register under rsp_stall while the next request
// is taken. Synchronous reset clears every valid bit and rank at once.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  lkvc_pkg::lkvc_request_type         req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output lkvc_pkg::lkvc_response_type        rsp_data,
   input  logic                               csr_wr_en,
   input  logic [lkvc_pkg::CSR_W-1:0]         csr_wr_data
);

   logic [lkvc_pkg::CSR_W-1:0]          cap_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   lkvc_pkg::lkvc_response_type         rsp_data_ff, rsp_data_in;

   logic                                idle;
   logic                                out_free;
   logic                                rsp_load;
   lkvc_pkg::lkvc_response_type         rsp_next;
   lkvc_pkg::lkvc_store_cmd_type        store_cmd;
   logic signed [lkvc_pkg::DATA_W-1:0]  rd_key;
   logic signed [lkvc_pkg::DATA_W-1:0]  rd_value;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lkvc_pkg::CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   // output register: drop on take, load when the sequencer hands over
   assign out_free = !(rsp_valid_ff && rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign req_stall = !idle;

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .capacity  (cap_ff),
      .req_valid (req_valid),
      .req_data  (req_data),
      .idle      (idle),
      .out_free  (out_free),
      .rsp_load  (rsp_load),
      .rsp_next  (rsp_next),
      .store_cmd (store_cmd),
      .rd_key    (rd_key),
      .rd_value  (rd_value)
   );

   lkvc_store u_store (
      .clock    (clock),
      .cmd      (store_cmd),
      .rd_key   (rd_key),
      .rd_value (rd_value)
   );

endmodule
